@@ hdl/dpfs_pkg.sv @@
package dpfs_pkg;

    localparam int BYTE_W    = 8;
    localparam int PIXEL_W   = 3 * BYTE_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CODE_STRAIGHT       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_CHAIN          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_CHAIN_REVERSED = 2'd2;

    localparam logic [BYTE_W-1:0] RST_CODE_STRAIGHT       = 8'd0;
    localparam logic [BYTE_W-1:0] RST_CODE_CHAIN          = 8'd1;
    localparam logic [BYTE_W-1:0] RST_CODE_CHAIN_REVERSED = 8'd2;

    typedef struct packed {
        logic is_read;
        logic out_of_range;
        logic refresh;
    } t_item_info;

endpackage

@@ hdl/dpfs_ram.sv @@
module dpfs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ hdl/dpfs_ctrl.sv @@
module dpfs_ctrl #(
    parameter int PIXEL_COUNT = 256
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_cfg_we,
    input  logic [dpfs_pkg::CFG_IDX_W-1:0]                i_cfg_index,
    input  logic [dpfs_pkg::BYTE_W-1:0]                   i_cfg_data,
    input  logic                                          i_item_we,
    input  logic                                          i_mode,
    input  logic [dpfs_pkg::BYTE_W-1:0]                   i_byte,
    input  logic                                          i_last,
    input  logic [dpfs_pkg::BYTE_W-1:0]                   i_index,
    output logic                                          o_busy,
    output dpfs_pkg::t_item_info                          o_info,
    output logic                                          o_mem_we,
    output logic [(PIXEL_COUNT > 1 ? $clog2(PIXEL_COUNT) : 1)-1:0] o_mem_waddr,
    output logic [dpfs_pkg::PIXEL_W-1:0]                  o_mem_wdata,
    output logic                                          o_mem_re,
    output logic [(PIXEL_COUNT > 1 ? $clog2(PIXEL_COUNT) : 1)-1:0] o_mem_raddr
);

    import dpfs_pkg::*;

    localparam int AW  = PIXEL_COUNT > 1 ? $clog2(PIXEL_COUNT) : 1;
    localparam int WPW = $clog2(PIXEL_COUNT + 1);
    localparam logic [AW:0]    COUNT_X   = (AW + 1)'(PIXEL_COUNT);
    localparam logic [AW-1:0]  LAST_ADDR = AW'(PIXEL_COUNT - 1);
    localparam logic [WPW-1:0] COUNT_WP  = WPW'(PIXEL_COUNT);

    typedef enum logic [1:0] {
        K_STRAIGHT,
        K_CHAIN,
        K_CHAIN_REV,
        K_UNKNOWN
    } t_kind;

    typedef enum logic [1:0] {
        POS_PROGRAM,
        POS_RED,
        POS_GREEN,
        POS_BLUE
    } t_pos;

    logic [BYTE_W-1:0]   r_code_straight, r_code_chain, r_code_chain_rev;
    logic [BYTE_W-1:0]   r_prog, n_prog;
    t_pos                r_pos, n_pos;
    logic [2*BYTE_W-1:0] r_part, n_part;
    logic [WPW-1:0]      r_wp, n_wp;
    logic                r_done, n_done;
    logic [AW-1:0]       r_head, n_head;
    logic                r_busy;
    logic [AW-1:0]       r_clr_addr;

    t_kind               kind_cur, kind_new;
    logic                pkt_we;
    logic                trip_we;
    logic [AW-1:0]       trip_addr;
    logic [AW:0]         wp_sum, rd_sum;
    logic [AW-1:0]       head_dec, head_inc;
    logic                rd_oor;
    logic                refresh;

    function automatic t_kind decode(input logic [BYTE_W-1:0] prog,
                                     input logic [BYTE_W-1:0] c_str,
                                     input logic [BYTE_W-1:0] c_chn,
                                     input logic [BYTE_W-1:0] c_rev);
        priority if (prog == c_str) begin
            return K_STRAIGHT;
        end else if (prog == c_chn) begin
            return K_CHAIN;
        end else if (prog == c_rev) begin
            return K_CHAIN_REV;
        end else begin
            return K_UNKNOWN;
        end
    endfunction

    always_comb begin
        pkt_we   = i_item_we && !i_mode;
        kind_cur = decode(r_prog, r_code_straight, r_code_chain, r_code_chain_rev);
        kind_new = K_UNKNOWN;

        wp_sum = {1'b0, r_head} + {1'b0, AW'(r_wp)};
        if (wp_sum >= COUNT_X) begin
            wp_sum = wp_sum - COUNT_X;
        end
        rd_oor = ({{(32 - BYTE_W){1'b0}}, i_index} >= 32'(PIXEL_COUNT));
        rd_sum = {1'b0, r_head} + {1'b0, AW'(i_index)};
        if (rd_sum >= COUNT_X) begin
            rd_sum = rd_sum - COUNT_X;
        end
        head_dec = (r_head == '0) ? LAST_ADDR : r_head - 1'b1;
        head_inc = (r_head == LAST_ADDR) ? '0 : r_head + 1'b1;

        n_prog    = r_prog;
        n_pos     = r_pos;
        n_part    = r_part;
        n_wp      = r_wp;
        n_done    = r_done;
        n_head    = r_head;
        trip_we   = 1'b0;
        trip_addr = wp_sum[AW-1:0];
        refresh   = 1'b0;

        if (pkt_we) begin
            unique case (r_pos)
                POS_PROGRAM: begin
                    n_prog = i_byte;
                    n_part = '0;
                    n_wp   = '0;
                    n_done = 1'b0;
                    n_pos  = POS_RED;
                end
                POS_RED: begin
                    n_part = {i_byte, {BYTE_W{1'b0}}};
                    n_pos  = POS_GREEN;
                end
                POS_GREEN: begin
                    n_part = {r_part[2*BYTE_W-1:BYTE_W], i_byte};
                    n_pos  = POS_BLUE;
                end
                default: begin
                    n_part = '0;
                    n_pos  = POS_RED;
                    unique case (kind_cur)
                        K_STRAIGHT: begin
                            if (r_wp < COUNT_WP) begin
                                trip_we   = 1'b1;
                                trip_addr = wp_sum[AW-1:0];
                                n_wp      = r_wp + 1'b1;
                            end
                        end
                        K_CHAIN: begin
                            if (!r_done) begin
                                trip_we   = 1'b1;
                                trip_addr = head_dec;
                                n_head    = head_dec;
                                n_done    = 1'b1;
                            end
                        end
                        K_CHAIN_REV: begin
                            if (!r_done) begin
                                trip_we   = 1'b1;
                                trip_addr = r_head;
                                n_head    = head_inc;
                                n_done    = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            endcase

            if (i_last) begin
                kind_new = decode(n_prog, r_code_straight, r_code_chain, r_code_chain_rev);
                refresh = (kind_new == K_CHAIN || kind_new == K_CHAIN_REV) ? n_done : 1'b1;
                n_pos   = POS_PROGRAM;
                n_part  = '0;
                n_wp    = '0;
                n_done  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_straight  <= RST_CODE_STRAIGHT;
            r_code_chain     <= RST_CODE_CHAIN;
            r_code_chain_rev <= RST_CODE_CHAIN_REVERSED;
            r_prog           <= '0;
            r_pos            <= POS_PROGRAM;
            r_part           <= '0;
            r_wp             <= '0;
            r_done           <= 1'b0;
            r_head           <= '0;
            r_busy           <= 1'b1;
            r_clr_addr       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CODE_STRAIGHT:       r_code_straight  <= i_cfg_data;
                    CFG_CODE_CHAIN:          r_code_chain     <= i_cfg_data;
                    CFG_CODE_CHAIN_REVERSED: r_code_chain_rev <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_prog <= n_prog;
            r_pos  <= n_pos;
            r_part <= n_part;
            r_wp   <= n_wp;
            r_done <= n_done;
            r_head <= n_head;
            if (r_busy) begin
                if (r_clr_addr == LAST_ADDR) begin
                    r_busy <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_busy              = r_busy;
        o_info.is_read      = i_mode;
        o_info.out_of_range = rd_oor;
        o_info.refresh      = refresh;
        o_mem_re            = i_item_we && i_mode && !rd_oor;
        o_mem_raddr         = rd_sum[AW-1:0];
        if (r_busy) begin
            o_mem_we    = 1'b1;
            o_mem_waddr = r_clr_addr;
            o_mem_wdata = '0;
        end else begin
            o_mem_we    = trip_we;
            o_mem_waddr = trip_addr;
            o_mem_wdata = {r_part, i_byte};
        end
    end

endmodule

@@ hdl/dmx_pixel_frame_store.sv @@
// Channel    Direction  Beat content
// s_axis     in         tuser mode, tdata {pixel_index, data_byte}, tlast last
// m_axis     out        tdata {blue, green, red}, tuser {refresh, read_valid}
// cfg        in         i_cfg_index register, i_cfg_data code byte
//
// One item is taken per cycle while the memory is not being cleared and the output is not stalled;
// each result passes through the memory read stage and the output register. After reset the pixel
// memory is cleared, during which s_axis_tready stays low; configuration writes are taken at any time outside reset.
// A stalled output holds its beat, and one more item is taken behind it.
module dmx_pixel_frame_store #(
    parameter int PIXEL_COUNT = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [2*dpfs_pkg::BYTE_W-1:0]        s_axis_tdata,  // data_byte, pixel_index
    input  logic                                 s_axis_tuser,  // mode
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [dpfs_pkg::PIXEL_W-1:0]         m_axis_tdata,  // red, green, blue
    output logic [1:0]                           m_axis_tuser,  // read_valid, refresh
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [dpfs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dpfs_pkg::BYTE_W-1:0]          i_cfg_data
);

    import dpfs_pkg::*;

    localparam int AW = PIXEL_COUNT > 1 ? $clog2(PIXEL_COUNT) : 1;

    logic              accept;
    logic              busy;
    t_item_info        info;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [PIXEL_W-1:0] mem_wdata, mem_rdata;

    logic              r_s1_v;
    t_item_info        r_s1_info;
    logic              s1_move;
    logic              r_out_v;
    logic [PIXEL_W-1:0] r_out_data;
    logic [1:0]        r_out_user;
    logic [PIXEL_W-1:0] s1_pixel;

    assign o_cfg_ready   = 1'b1;
    assign s1_move       = r_s1_v && (!r_out_v || m_axis_tready);
    assign s_axis_tready = !busy && (!r_s1_v || s1_move);
    assign accept        = s_axis_tvalid && s_axis_tready;

    dpfs_ctrl #(
        .PIXEL_COUNT(PIXEL_COUNT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item_we   (accept),
        .i_mode      (s_axis_tuser),
        .i_byte      (s_axis_tdata[BYTE_W-1:0]),
        .i_last      (s_axis_tlast),
        .i_index     (s_axis_tdata[2*BYTE_W-1:BYTE_W]),
        .o_busy      (busy),
        .o_info      (info),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr)
    );

    dpfs_ram #(
        .WIDTH(PIXEL_W),
        .DEPTH(PIXEL_COUNT)
    ) u_pixel_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign s1_pixel = (r_s1_info.is_read && !r_s1_info.out_of_range) ? mem_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_v <= 1'b1;
            end else if (s1_move) begin
                r_s1_v <= 1'b0;
            end
            if (s1_move) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_info <= info;
        end
        if (s1_move) begin
            r_out_data <= {s1_pixel[BYTE_W-1:0],
                           s1_pixel[2*BYTE_W-1:BYTE_W],
                           s1_pixel[3*BYTE_W-1:2*BYTE_W]};
            r_out_user <= {r_s1_info.refresh, r_s1_info.is_read};
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

@@ bench/dmx_pixel_frame_store_tb.sv @@
`timescale 1ns / 1ps

module dmx_pixel_frame_store_tb;
    import dpfs_pkg::*;

    localparam int PIXEL_COUNT = 256;

    typedef enum logic [1:0] {
        PROG_STRAIGHT,
        PROG_CHAIN,
        PROG_CHAIN_REVERSED,
        PROG_UNKNOWN
    } t_program_kind;

    typedef enum logic [1:0] {
        SLOT_PROGRAM,
        SLOT_RED,
        SLOT_GREEN,
        SLOT_BLUE
    } t_byte_slot;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       read_valid;
        logic       refresh;
    } t_pixel_beat;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata;   // data_byte, pixel_index
    logic                 s_axis_tuser;   // mode
    logic                 s_axis_tlast;   // last
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [PIXEL_W-1:0]   m_axis_tdata;   // red, green, blue
    logic [1:0]           m_axis_tuser;   // read_valid, refresh
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [BYTE_W-1:0]    i_cfg_data;

    dmx_pixel_frame_store #(
        .PIXEL_COUNT(PIXEL_COUNT)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [PIXEL_W-1:0] frame_pixels [PIXEL_COUNT];
    logic [7:0]         pkt_program;
    t_byte_slot         byte_slot;
    logic [15:0]        open_pair;
    int unsigned        straight_ptr;
    logic               chain_shifted;
    logic [7:0]         code_straight;
    logic [7:0]         code_chain;
    logic [7:0]         code_chain_reversed;

    t_pixel_beat pending_beats [$];

    int  items_sent;
    int  reads_sent;
    int  refresh_expected;
    int  cfg_writes;
    int  beats_checked;
    int  mismatches;
    bit  send_burst;
    bit  recv_burst;

    function automatic t_program_kind decode_program();
        if (pkt_program == code_straight) return PROG_STRAIGHT;
        if (pkt_program == code_chain) return PROG_CHAIN;
        if (pkt_program == code_chain_reversed) return PROG_CHAIN_REVERSED;
        return PROG_UNKNOWN;
    endfunction

    task automatic store_triple(input logic [PIXEL_W-1:0] px);
        case (decode_program())
            PROG_STRAIGHT: begin
                if (straight_ptr < PIXEL_COUNT) begin
                    frame_pixels[straight_ptr] = px;
                    straight_ptr++;
                end
            end
            PROG_CHAIN: begin
                if (!chain_shifted) begin
                    for (int i = PIXEL_COUNT - 1; i > 0; i--) frame_pixels[i] = frame_pixels[i-1];
                    frame_pixels[0] = px;
                    chain_shifted = 1'b1;
                end
            end
            PROG_CHAIN_REVERSED: begin
                if (!chain_shifted) begin
                    for (int i = 0; i < PIXEL_COUNT - 1; i++) frame_pixels[i] = frame_pixels[i+1];
                    frame_pixels[PIXEL_COUNT-1] = px;
                    chain_shifted = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    task automatic predict_beat(input logic mode, input logic [7:0] dbyte, input logic lst,
                                input logic [7:0] idx);
        t_pixel_beat   beat;
        t_program_kind kind;
        beat.red = 8'h00;
        beat.green = 8'h00;
        beat.blue = 8'h00;
        beat.read_valid = 1'b0;
        beat.refresh = 1'b0;
        if (mode) begin
            if (idx < PIXEL_COUNT) {beat.red, beat.green, beat.blue} = frame_pixels[idx];
            beat.read_valid = 1'b1;
        end else begin
            case (byte_slot)
                SLOT_PROGRAM: begin
                    pkt_program = dbyte;
                    open_pair = 16'h0000;
                    straight_ptr = 0;
                    chain_shifted = 1'b0;
                    byte_slot = SLOT_RED;
                end
                SLOT_RED: begin
                    open_pair = {dbyte, 8'h00};
                    byte_slot = SLOT_GREEN;
                end
                SLOT_GREEN: begin
                    open_pair[7:0] = dbyte;
                    byte_slot = SLOT_BLUE;
                end
                default: begin
                    store_triple({open_pair, dbyte});
                    open_pair = 16'h0000;
                    byte_slot = SLOT_RED;
                end
            endcase
            if (lst) begin
                kind = decode_program();
                if (kind == PROG_CHAIN || kind == PROG_CHAIN_REVERSED)
                    beat.refresh = chain_shifted;
                else
                    beat.refresh = 1'b1;
                byte_slot = SLOT_PROGRAM;
                open_pair = 16'h0000;
                straight_ptr = 0;
                chain_shifted = 1'b0;
            end
        end
        if (beat.refresh) refresh_expected++;
        pending_beats.push_back(beat);
    endtask

    task automatic send_item(input logic mode, input logic [7:0] dbyte, input logic lst,
                             input logic [7:0] idx);
        int gap;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {idx, dbyte};
        s_axis_tlast  <= lst;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        predict_beat(mode, dbyte, lst, idx);
        items_sent++;
        if (mode) reads_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] dbyte, input logic lst);
        send_item(1'b0, dbyte, lst, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_read(input logic [7:0] idx);
        send_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), idx);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_beats.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_code(input logic [CFG_IDX_W-1:0] index, input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (index)
            CFG_CODE_STRAIGHT:       code_straight = value;
            CFG_CODE_CHAIN:          code_chain = value;
            CFG_CODE_CHAIN_REVERSED: code_chain_reversed = value;
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_codes(input logic [7:0] straight, input logic [7:0] chain,
                             input logic [7:0] chain_rev);
        write_code(CFG_CODE_STRAIGHT, straight);
        write_code(CFG_CODE_CHAIN, chain);
        write_code(CFG_CODE_CHAIN_REVERSED, chain_rev);
    endtask

    function automatic logic [7:0] pick_index();
        case ($urandom_range(0, 2))
            0:       return 8'($urandom_range(0, 7));
            1:       return 8'($urandom_range(PIXEL_COUNT - 8, PIXEL_COUNT - 1));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_reads_after_reset();
        send_read(8'h00);
        send_item(1'b1, 8'hFF, 1'b1, 8'hFF);
        wait_idle();
    endtask

    task automatic test_straight_program();
        send_byte(RST_CODE_STRAIGHT, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h5A, 1'b1);
        send_read(8'h00);
        send_read(8'h01);
        wait_idle();
    endtask

    task automatic test_chain_programs();
        send_byte(RST_CODE_CHAIN, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b1);
        send_read(8'h01);
        // A reversed chain packet without a full triple must not refresh.
        send_byte(RST_CODE_CHAIN_REVERSED, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hBB, 1'b1);
        send_byte(RST_CODE_CHAIN_REVERSED, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b1);
        send_read(8'hFF);
        wait_idle();
    endtask

    task automatic test_program_codes();
        send_byte(8'hFF, 1'b1);
        wait_idle();
        // With equal codes straight takes precedence, then chain.
        set_codes(8'h55, 8'h55, 8'h55);
        send_byte(8'h55, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h99, 1'b1);
        wait_idle();
        set_codes(8'h00, 8'h66, 8'h66);
        send_byte(8'h66, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b1);
        // The program byte is decoded again on every beat of the packet.
        send_byte(8'h80, 1'b0);
        wait_idle();
        write_code(CFG_CODE_CHAIN_REVERSED, 8'h80);
        send_byte(8'hDE, 1'b0);
        send_byte(8'hAD, 1'b0);
        send_byte(8'hBE, 1'b1);
        send_read(8'h00);
        send_read(8'hFF);
        wait_idle();
    endtask

    task automatic test_full_store();
        send_byte(code_straight, 1'b0);
        for (int k = 0; k < 3 * (PIXEL_COUNT + 2); k++)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        for (int k = 0; k < 6; k++) send_read(pick_index());
        wait_idle();
    endtask

    task automatic send_random_packet();
        logic [7:0] prog;
        int         triples;
        int         extra;
        int         total;
        case ($urandom_range(0, 4))
            0, 1:    prog = code_straight;
            2:       prog = code_chain;
            3:       prog = code_chain_reversed;
            default: prog = 8'($urandom_range(0, 255));
        endcase
        triples = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        total = 3 * triples + extra;
        send_byte(prog, total == 0);
        for (int k = 0; k < total; k++) begin
            if ($urandom_range(0, 5) == 0) send_read(pick_index());
            send_byte(8'($urandom_range(0, 255)), k == total - 1);
        end
        if ($urandom_range(0, 1) == 0) send_read(pick_index());
    endtask

    task automatic run_random_traffic(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count) begin
            if ($urandom_range(0, 9) == 0)
                send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          $urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
            else
                send_random_packet();
        end
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [7:0] shared;
        set_codes(RST_CODE_STRAIGHT, RST_CODE_CHAIN, RST_CODE_CHAIN_REVERSED);
        run_random_traffic(60);
        set_codes(8'hFF, 8'h00, 8'h80);
        run_random_traffic(60);
        set_codes(8'h00, 8'hFF, 8'hFE);
        run_random_traffic(60);
        set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
        run_random_traffic(60);
        shared = 8'($urandom_range(0, 255));
        set_codes(shared, shared, shared ^ 8'h01);
        run_random_traffic(60);
        set_codes(shared ^ 8'h01, shared, shared);
        run_random_traffic(60);
    endtask

    always @(posedge i_clk) begin
        t_pixel_beat want;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            beats_checked++;
            if (pending_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat: data=%06h user=%02b",
                             m_axis_tdata, m_axis_tuser);
            end else begin
                want = pending_beats.pop_front();
                if (m_axis_tdata[7:0] !== want.red || m_axis_tdata[15:8] !== want.green ||
                    m_axis_tdata[23:16] !== want.blue || m_axis_tuser[0] !== want.read_valid ||
                    m_axis_tuser[1] !== want.refresh) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Beat %0d: expected r=%02h g=%02h b=%02h read=%0b refresh=%0b",
                                 beats_checked, want.red, want.green, want.blue,
                                 want.read_valid, want.refresh);
                        $display("    got r=%02h g=%02h b=%02h read=%0b refresh=%0b",
                                 m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                                 m_axis_tuser[0], m_axis_tuser[1]);
                    end
                end
            end
        end
    end

    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            @(negedge i_clk);
        end
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d result beats outstanding.", pending_beats.size());
        $display("dmx_pixel_frame_store: mismatch");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        for (int i = 0; i < PIXEL_COUNT; i++) frame_pixels[i] = '0;
        pkt_program = 8'h00;
        byte_slot = SLOT_PROGRAM;
        open_pair = 16'h0000;
        straight_ptr = 0;
        chain_shifted = 1'b0;
        code_straight = RST_CODE_STRAIGHT;
        code_chain = RST_CODE_CHAIN;
        code_chain_reversed = RST_CODE_CHAIN_REVERSED;
        items_sent = 0;
        reads_sent = 0;
        refresh_expected = 0;
        cfg_writes = 0;
        beats_checked = 0;
        mismatches = 0;
        send_burst = 1'b0;
        recv_burst = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reads_after_reset();
        test_straight_program();
        test_chain_programs();
        test_program_codes();
        test_full_store();
        test_random_traffic();

        if (pending_beats.size() != 0) begin
            $display("%0d expected result beats never arrived.", pending_beats.size());
            mismatches += pending_beats.size();
        end
        $display("Sent %0d items (%0d pixel reads) across %0d register writes.",
                 items_sent, reads_sent, cfg_writes);
        $display("Checked %0d result beats, %0d with refresh, %0d mismatches.",
                 beats_checked, refresh_expected, mismatches);
        if (mismatches == 0) begin
            $display("dmx_pixel_frame_store: match");
        end else begin
            $display("dmx_pixel_frame_store: mismatch");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/dpfs_pkg.sv
hdl/dpfs_ram.sv
hdl/dpfs_ctrl.sv
hdl/dmx_pixel_frame_store.sv
bench/dmx_pixel_frame_store_tb.sv
